@@ sv/lsp_pkg.sv @@
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types, constants and the CORDIC step for the LiDAR spherical
// projection block.
// ----------------------------------------------------------------------------
package lsp_pkg;

	// image limits applied to the size registers
	localparam int MAX_COLUMNS = 4096;
	localparam int MAX_ROWS    = 256;

	// field and register widths
	localparam int COORD_W    = 32;
	localparam int COL_W      = 12;
	localparam int ROW_W      = 8;
	localparam int COLS_REG_W = 13;
	localparam int ROWS_REG_W = 9;
	localparam int FOV_REG_W  = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	// binary angles: 2^32 is one full turn
	localparam int PHASE_W = 32;
	localparam int CORDIC_W = 51;
	localparam int ARC_N = 32;
	localparam logic [PHASE_W-1:0] HALF_TURN = 32'h8000_0000;
	// centidegrees in a full turn, scaling the pitch phase
	localparam logic [16:0] PITCH_SCALE = 17'd36000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_COLUMNS = 2'd0,
		REG_IMAGE_ROWS    = 2'd1,
		REG_FOV_UP        = 2'd2,
		REG_FOV_DOWN      = 2'd3
	} cfg_reg_t;

	// atan(2^-i) as binary angles
	localparam logic [PHASE_W-1:0] ARC_STEP [ARC_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic [COL_W-1:0] column_index;
		logic [ROW_W-1:0] row_index;
		logic             point_invalid;
	} pixel_t;

	// settled configuration: sizes clamped, field of view as magnitudes
	typedef struct packed {
		logic [COLS_REG_W-1:0] columns;
		logic [ROWS_REG_W-1:0] rows;
		logic [FOV_REG_W-1:0]  fov_up_abs;
		logic [FOV_REG_W:0]    fov_total;
	} cfg_t;

	// CORDIC vector with its angle accumulator
	typedef struct packed {
		logic signed [CORDIC_W-1:0] px;
		logic signed [CORDIC_W-1:0] py;
		logic [PHASE_W-1:0]         acc;
	} vec_t;

	// one vectoring iteration, driving py towards zero
	function automatic vec_t vec_step(vec_t v, int i);
		vec_t r;
		logic signed [CORDIC_W-1:0] dx;
		logic signed [CORDIC_W-1:0] dy;
		dx = v.py >>> i;
		dy = v.px >>> i;
		if (v.py[CORDIC_W-1]) begin
			r.px  = v.px - dx;
			r.py  = v.py + dy;
			r.acc = v.acc - ARC_STEP[i[4:0]];
		end else begin
			r.px  = v.px + dx;
			r.py  = v.py - dy;
			r.acc = v.acc + ARC_STEP[i[4:0]];
		end
		return r;
	endfunction

endpackage

@@ sv/lsp_if.sv @@
// ----------------------------------------------------------------------------
// lsp_if
// Handshake channels of the LiDAR spherical projection block: points in,
// pixel positions out, and the register write channel.
// ----------------------------------------------------------------------------
interface lsp_point_if;
	import lsp_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] point_z;
	modport source(output valid, output point_x, output point_y, output point_z,
		input ready);
	modport sink(input valid, input point_x, input point_y, input point_z,
		output ready);
endinterface

interface lsp_pixel_if;
	import lsp_pkg::*;
	logic             valid;
	logic             ready;
	logic [COL_W-1:0] column_index;
	logic [ROW_W-1:0] row_index;
	logic             point_invalid;
	modport source(output valid, output column_index, output row_index,
		output point_invalid, input ready);
	modport sink(input valid, input column_index, input row_index,
		input point_invalid, output ready);
endinterface

interface lsp_cfg_if;
	import lsp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

@@ sv/lsp_core.sv @@
// ----------------------------------------------------------------------------
// lsp_core
// Projection pipeline: squares, 32-stage square root, yaw and pitch CORDIC
// chains, row scaling, 9-stage row divider. One item per cycle if not stalled.
// ----------------------------------------------------------------------------
module lsp_core #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lsp_pkg::point_t in_point,
	output logic            out_valid,
	input  logic            out_ready,
	output lsp_pkg::pixel_t out_pixel,
	input  lsp_pkg::cfg_t   cfg
);
	import lsp_pkg::*;

	localparam int ROOT_W = COORD_W;
	localparam int SQ_W   = 2 * COORD_W;
	localparam int REM_W  = ROOT_W + 2;
	localparam int QUO_W  = $clog2(MAX_ROWS) + 1;
	localparam int NUM_W  = FOV_REG_W + PHASE_W + 2;
	localparam int P36_W  = NUM_W - 1;
	localparam int PROD_W = ROWS_REG_W + P36_W;
	localparam int Q_W    = PROD_W - PHASE_W;
	localparam int UPR_W  = COLS_REG_W + PHASE_W;

	// stage map
	localparam int S_SUM  = 1;
	localparam int S_SQ0  = 2;
	localparam int S_PPRE = S_SQ0 + ROOT_W;
	localparam int S_PC0  = S_PPRE + 1;
	localparam int S_P36  = S_PC0 + CORDIC_STAGES;
	localparam int S_NUM  = S_P36 + 1;
	localparam int S_PROD = S_NUM + 1;
	localparam int S_QUO  = S_PROD + 1;
	localparam int S_DIV0 = S_QUO + 1;
	localparam int S_FIN  = S_DIV0 + QUO_W;
	localparam int NS     = S_FIN + 1;

	typedef struct packed {
		logic                      zero;
		logic                      axis;
		vec_t                      yv;
		logic signed [COORD_W-1:0] z;
		logic [SQ_W-1:0]           xx;
		logic [SQ_W-1:0]           yy;
		logic [SQ_W-1:0]           rad;
		logic [REM_W-1:0]          srem;
		logic [ROOT_W-1:0]         sroot;
		vec_t                      pv;
		logic [UPR_W-1:0]          uprod;
		logic [COL_W-1:0]          col;
		logic signed [P36_W-1:0]   p36;
		logic signed [NUM_W-1:0]   num;
		logic                      pos;
		logic [PROD_W-1:0]         prod;
		logic                      sat;
		logic [Q_W-1:0]            drem;
		logic [QUO_W-1:0]          quo;
		logic [ROW_W-1:0]          row;
	} work_t;

	// first stage: squares, zero tests, yaw moved into the right half plane
	function automatic work_t load(point_t p);
		work_t w;
		logic signed [SQ_W-1:0] xl;
		logic signed [SQ_W-1:0] yl;
		w  = '0;
		xl = p.point_x;
		yl = p.point_y;
		w.axis = (p.point_x == '0) && (p.point_y == '0);
		w.zero = w.axis && (p.point_z == '0);
		w.xx = xl * xl;
		w.yy = yl * yl;
		w.z  = p.point_z;
		w.yv.px  = {{(CORDIC_W-COORD_W-16){p.point_x[COORD_W-1]}}, p.point_x, 16'h0000};
		w.yv.py  = {{(CORDIC_W-COORD_W-16){p.point_y[COORD_W-1]}}, p.point_y, 16'h0000};
		w.yv.acc = '0;
		if (p.point_x[COORD_W-1]) begin
			w.yv.px  = -w.yv.px;
			w.yv.py  = -w.yv.py;
			w.yv.acc = HALF_TURN;
		end
		return w;
	endfunction

	// work done by stage s on the item leaving stage s-1
	function automatic work_t advance(work_t p, int s, cfg_t c);
		work_t w;
		int i;
		logic [REM_W+1:0]      r2;
		logic [REM_W+1:0]      t2;
		logic [PHASE_W-1:0]    yaw;
		logic [PHASE_W-1:0]    turn;
		logic [COLS_REG_W-1:0] ucoarse;
		logic signed [P36_W-1:0] pe;
		logic [Q_W-1:0]        trial;
		logic [ROWS_REG_W-1:0] rlast;
		logic [ROWS_REG_W-1:0] vsel;
		w = p;
		// radicand
		if (s == S_SUM) begin
			w.rad   = p.xx + p.yy;
			w.srem  = '0;
			w.sroot = '0;
		end
		// square root, one result bit per stage
		if (s >= S_SQ0 && s < S_SQ0 + ROOT_W) begin
			r2 = {p.srem, p.rad[SQ_W-1 -: 2]};
			t2 = {2'b00, p.sroot, 2'b01};
			w.rad = {p.rad[SQ_W-3:0], 2'b00};
			if (r2 >= t2) begin
				w.srem  = REM_W'(r2 - t2);
				w.sroot = {p.sroot[ROOT_W-2:0], 1'b1};
			end else begin
				w.srem  = r2[REM_W-1:0];
				w.sroot = {p.sroot[ROOT_W-2:0], 1'b0};
			end
		end
		// yaw CORDIC alongside the root
		if (s >= S_SQ0 && s < S_SQ0 + CORDIC_STAGES) begin
			w.yv = vec_step(p.yv, s - S_SQ0);
		end
		// pitch vector set up, column product
		if (s == S_PPRE) begin
			w.pv.px  = {{(CORDIC_W-ROOT_W-16){1'b0}}, p.sroot, 16'h0000};
			w.pv.py  = {{(CORDIC_W-COORD_W-16){p.z[COORD_W-1]}}, p.z, 16'h0000};
			w.pv.acc = '0;
			yaw  = p.axis ? '0 : p.yv.acc;
			turn = HALF_TURN - yaw;
			w.uprod = {{PHASE_W{1'b0}}, c.columns} * {{COLS_REG_W{1'b0}}, turn};
		end
		// pitch CORDIC
		if (s >= S_PC0 && s < S_PC0 + CORDIC_STAGES) begin
			w.pv = vec_step(p.pv, s - S_PC0);
		end
		// pitch in centidegree units, column clamp
		if (s == S_P36) begin
			pe = {{(P36_W-PHASE_W){p.pv.acc[PHASE_W-1]}}, p.pv.acc};
			w.p36 = pe * $signed({{(P36_W-17){1'b0}}, PITCH_SCALE});
			ucoarse = p.uprod[UPR_W-1:PHASE_W];
			if (ucoarse > c.columns - 1'b1) begin
				ucoarse = c.columns - 1'b1;
			end
			w.col = ucoarse[COL_W-1:0];
		end
		// distance below the upper edge of the field of view
		if (s == S_NUM) begin
			w.num = $signed({2'b00, c.fov_up_abs, {PHASE_W{1'b0}}})
				- {p.p36[P36_W-1], p.p36};
		end
		if (s == S_PROD) begin
			w.pos  = !p.num[NUM_W-1] && (p.num != '0);
			w.prod = {{P36_W{1'b0}}, c.rows} * {{ROWS_REG_W{1'b0}}, p.num[P36_W-1:0]};
		end
		// dividend, and saturation when the quotient cannot fit
		if (s == S_QUO) begin
			w.drem = p.prod[PROD_W-1:PHASE_W];
			w.sat  = p.prod[PROD_W-1:PHASE_W] >= {c.fov_total, {QUO_W{1'b0}}};
			w.quo  = '0;
		end
		// restoring divide by the field of view, most significant bit first
		if (s >= S_DIV0 && s < S_DIV0 + QUO_W) begin
			i = QUO_W - 1 - (s - S_DIV0);
			trial = {{(Q_W-FOV_REG_W-1){1'b0}}, c.fov_total} << i;
			if (p.drem >= trial) begin
				w.drem = p.drem - trial;
				w.quo[i[$clog2(QUO_W)-1:0]] = 1'b1;
			end
		end
		// row clamp and the special cases
		if (s == S_FIN) begin
			rlast = c.rows - 1'b1;
			vsel  = (p.sat || (p.quo > rlast)) ? rlast : p.quo;
			if ((c.fov_total == '0) || !p.pos) begin
				vsel = '0;
			end
			w.row = vsel[ROW_W-1:0];
			if (p.zero) begin
				w.row = '0;
				w.col = '0;
			end
		end
		return w;
	endfunction

	work_t pipe_s [NS];
	work_t nxt [NS];
	logic  vld_s [NS];
	logic  vin [NS];
	logic  en [NS];

	// stage registers with per-stage flow control
	for (genvar s = 0; s < NS; s++) begin : g_stage
		if (s == 0) begin : g_head
			assign nxt[s] = load(in_point);
			assign vin[s] = in_valid;
		end else begin : g_body
			assign nxt[s] = advance(pipe_s[s-1], s, cfg);
			assign vin[s] = vld_s[s-1];
		end
		if (s == NS - 1) begin : g_tail_en
			assign en[s] = !vld_s[s] || out_ready;
		end else begin : g_body_en
			assign en[s] = !vld_s[s] || en[s+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else if (en[s]) begin
				vld_s[s] <= vin[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en[s]) begin
				pipe_s[s] <= nxt[s];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_s[NS-1];
	assign out_pixel.column_index  = pipe_s[NS-1].col;
	assign out_pixel.row_index     = pipe_s[NS-1].row;
	assign out_pixel.point_invalid = pipe_s[NS-1].zero;

	// an empty output stage never holds the input back
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output stage");

	// an accepted item occupies the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_s[0])
		else $error("accepted item lost at entry");

	// an invalid point reports the origin pixel
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_pixel.point_invalid) |->
		(out_pixel.column_index == '0) && (out_pixel.row_index == '0))
		else $error("invalid point with nonzero pixel");

	// results stay inside the image
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, out_pixel.column_index} < cfg.columns)
		&& ({1'b0, out_pixel.row_index} < cfg.rows))
		else $error("pixel outside the image");

endmodule

@@ sv/lidar_spherical_projection.sv @@
// ----------------------------------------------------------------------------
// lidar_spherical_projection
// Projects LiDAR points (x, y, z in signed Q16.16 metres) onto the column
// and row of a range image, flagging points at the origin.
// ----------------------------------------------------------------------------
// One point is taken every cycle while the output is not stalled, and one
// pixel position comes out for each, in order. The pipeline depth comes
// mainly from the 32-stage square root of x*x + y*y, the pitch CORDIC chain
// that follows it and the 9-stage row divider; the yaw CORDIC runs beside
// the root. Any stage frees up as soon as the next one moves, so the input
// keeps flowing while the output holds a finished item, until every stage
// is full. Register writes are taken at once and must happen while no point
// is in flight.
module lidar_spherical_projection #(
	parameter int CORDIC_STAGES = 16
) (
	input logic         clk,
	input logic         arst_n,
	lsp_point_if.sink   point,
	lsp_pixel_if.source pixel,
	lsp_cfg_if.sink     cfg
);
	import lsp_pkg::*;

	logic [COLS_REG_W-1:0]       image_columns_q;
	logic [ROWS_REG_W-1:0]       image_rows_q;
	logic signed [FOV_REG_W-1:0] fov_up_q;
	logic signed [FOV_REG_W-1:0] fov_down_q;
	logic [FOV_REG_W-1:0]        fov_up_abs;
	logic [FOV_REG_W-1:0]        fov_down_abs;
	cfg_t                        cfg_c;
	point_t                      in_point;
	pixel_t                      out_pixel;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_columns_q <= 13'd2048;
			image_rows_q    <= 9'd64;
			fov_up_q        <= 15'sd300;
			fov_down_q      <= -15'sd2500;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_IMAGE_COLUMNS: image_columns_q <= cfg.data[COLS_REG_W-1:0];
				REG_IMAGE_ROWS:    image_rows_q    <= cfg.data[ROWS_REG_W-1:0];
				REG_FOV_UP:        fov_up_q        <= cfg.data[FOV_REG_W-1:0];
				REG_FOV_DOWN:      fov_down_q      <= cfg.data[FOV_REG_W-1:0];
			endcase
		end
	end

	// sizes clamped into range, field of view as magnitudes
	always_comb begin
		cfg_c.columns = image_columns_q;
		if (image_columns_q == '0) begin
			cfg_c.columns = COLS_REG_W'(1);
		end else if (image_columns_q > COLS_REG_W'(MAX_COLUMNS)) begin
			cfg_c.columns = COLS_REG_W'(MAX_COLUMNS);
		end
		cfg_c.rows = image_rows_q;
		if (image_rows_q == '0) begin
			cfg_c.rows = ROWS_REG_W'(1);
		end else if (image_rows_q > ROWS_REG_W'(MAX_ROWS)) begin
			cfg_c.rows = ROWS_REG_W'(MAX_ROWS);
		end
		fov_up_abs   = fov_up_q[FOV_REG_W-1] ? -fov_up_q : fov_up_q;
		fov_down_abs = fov_down_q[FOV_REG_W-1] ? -fov_down_q : fov_down_q;
		cfg_c.fov_up_abs = fov_up_abs;
		cfg_c.fov_total  = {1'b0, fov_up_abs} + {1'b0, fov_down_abs};
	end

	assign in_point.point_x = point.point_x;
	assign in_point.point_y = point.point_y;
	assign in_point.point_z = point.point_z;

	lsp_core #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (point.valid),
		.in_ready (point.ready),
		.in_point (in_point),
		.out_valid(pixel.valid),
		.out_ready(pixel.ready),
		.out_pixel(out_pixel),
		.cfg      (cfg_c)
	);

	assign pixel.column_index  = out_pixel.column_index;
	assign pixel.row_index     = out_pixel.row_index;
	assign pixel.point_invalid = out_pixel.point_invalid;

endmodule

@@ bench/lidar_spherical_projection_tb.sv @@
// ----------------------------------------------------------------------------
// lidar_spherical_projection_tb
// Self-checking bench for the LiDAR spherical projection block. Points are
// driven with random gaps, pixel positions are taken with random stalls and
// compared field by field with a bit-exact fixed-point projection model.
// Several image and field-of-view settings are exercised, extremes included.
// ----------------------------------------------------------------------------
module lidar_spherical_projection_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lsp_pkg::*;

	// expected pixel positions and their checking
	class pixel_scoreboard;
		pixel_t pending[$];
		int     errors;

		function new();
			errors = 0;
		endfunction

		function void note_point(pixel_t exp_px);
			pending.push_back(exp_px);
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t exp_px;
			if (pending.size() == 0) begin
				$display("%0t: unexpected pixel col=%0d row=%0d inv=%0d", $time,
					got.column_index, got.row_index, got.point_invalid);
				errors++;
				return;
			end
			exp_px = pending.pop_front();
			if (got.column_index !== exp_px.column_index) begin
				$display("%0t: column expected %0d actual %0d", $time,
					exp_px.column_index, got.column_index);
				errors++;
			end
			if (got.row_index !== exp_px.row_index) begin
				$display("%0t: row expected %0d actual %0d", $time,
					exp_px.row_index, got.row_index);
				errors++;
			end
			if (got.point_invalid !== exp_px.point_invalid) begin
				$display("%0t: invalid flag expected %0d actual %0d", $time,
					exp_px.point_invalid, got.point_invalid);
				errors++;
			end
		endfunction
	endclass

	localparam int STAGES     = 16;
	localparam int LATENCY    = 48 + STAGES;
	localparam int IDLE_LIMIT = 4000;
	localparam int N_RANDOM   = 900;

	logic clk;
	logic arst_n;

	lsp_point_if point();
	lsp_pixel_if pixel();
	lsp_cfg_if   cfg();

	lidar_spherical_projection #(.CORDIC_STAGES(STAGES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.point(point.sink),
		.pixel(pixel.source),
		.cfg(cfg.sink)
	);

	pixel_scoreboard sb;

	// model copy of the registers
	logic [COLS_REG_W-1:0]       m_cols;
	logic [ROWS_REG_W-1:0]       m_rows;
	logic signed [FOV_REG_W-1:0] m_fov_up;
	logic signed [FOV_REG_W-1:0] m_fov_down;

	int  idle_cycles;
	bit  stall_long;
	bit  stim_done;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// arithmetic shift toward minus infinity
	function automatic longint sar(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// vectoring phase of (px, py), 2^32 per turn
	function automatic logic [31:0] phase_of(longint px, longint py);
		logic [31:0] acc;
		longint dx, dy;
		acc = 0;
		if (px < 0) begin
			px = -px;
			py = -py;
			acc = HALF_TURN;
		end
		for (int i = 0; i < STAGES; i++) begin
			dx = sar(py, i);
			dy = sar(px, i);
			if (py < 0) begin
				px -= dx;
				py += dy;
				acc -= ARC_STEP[i];
			end else begin
				px += dx;
				py -= dy;
				acc += ARC_STEP[i];
			end
		end
		return acc;
	endfunction

	function automatic pixel_t project_point(point_t p);
		pixel_t r;
		longint x, y, z, fu, fd, fov, pitch, num;
		longint unsigned cols, rows, u, v, rho;
		logic [31:0] yaw, pq, t;
		x = p.point_x;
		y = p.point_y;
		z = p.point_z;
		r = '0;
		if (x == 0 && y == 0 && z == 0) begin
			r.point_invalid = 1'b1;
			return r;
		end
		cols = m_cols;
		rows = m_rows;
		if (cols < 1) cols = 1;
		if (cols > MAX_COLUMNS) cols = MAX_COLUMNS;
		if (rows < 1) rows = 1;
		if (rows > MAX_ROWS) rows = MAX_ROWS;
		yaw = (x == 0 && y == 0) ? 32'd0 : phase_of(x * 65536, y * 65536);
		t = HALF_TURN - yaw;
		u = (cols * longint'(t)) >> 32;
		if (u > cols - 1) u = cols - 1;
		rho = isqrt(longint'(x * x) + longint'(y * y));
		pq = phase_of(longint'(rho) * 65536, z * 65536);
		pitch = pq[31] ? longint'(pq) - (64'sd1 <<< 32) : longint'(pq);
		fu = m_fov_up < 0 ? -longint'(m_fov_up) : longint'(m_fov_up);
		fd = m_fov_down < 0 ? -longint'(m_fov_down) : longint'(m_fov_down);
		fov = fu + fd;
		v = 0;
		if (fov != 0) begin
			num = fu * (64'sd1 <<< 32) - 36000 * pitch;
			if (num > 0) begin
				// rows * num fits in 64 bits unsigned only with care: use 128
				v = 64'((128'(rows) * 128'($unsigned(num)))
					/ (128'($unsigned(fov)) << 32));
				if (v > rows - 1) v = rows - 1;
			end
		end
		r.column_index = u[COL_W-1:0];
		r.row_index = v[ROW_W-1:0];
		return r;
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		cfg.index <= idx;
		cfg.data <= value;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_IMAGE_COLUMNS: m_cols = value[COLS_REG_W-1:0];
			REG_IMAGE_ROWS:    m_rows = value[ROWS_REG_W-1:0];
			REG_FOV_UP:        m_fov_up = value;
			REG_FOV_DOWN:      m_fov_down = value;
		endcase
	endtask

	task automatic setup(int c, int r, int up, int down);
		write_reg(REG_IMAGE_COLUMNS, CFG_DATA_W'(c));
		write_reg(REG_IMAGE_ROWS, CFG_DATA_W'(r));
		write_reg(REG_FOV_UP, CFG_DATA_W'(up));
		write_reg(REG_FOV_DOWN, CFG_DATA_W'(down));
		cfg.valid <= 1'b0;
	endtask

	// offer one point, optional random gap first
	task automatic send_point(point_t p, bit gaps);
		int gap;
		gap = gaps ? ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17)) : 0;
		if (gap != 0) begin
			point.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point.point_x <= p.point_x;
		point.point_y <= p.point_y;
		point.point_z <= p.point_z;
		point.valid <= 1'b1;
		do @(posedge clk); while (!point.ready);
		sb.note_point(project_point(p));
	endtask

	task automatic drain();
		point.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
			2: return 32'($signed($urandom_range(0, 200)) - 100);
			3: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
			4: return 32'h0;
			default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, 16'($urandom)};
		endcase
	endfunction

	task automatic random_points(int n, bit gaps);
		point_t p;
		for (int i = 0; i < n; i++) begin
			p.point_x = rand_coord();
			p.point_y = rand_coord();
			p.point_z = rand_coord();
			send_point(p, gaps);
		end
	endtask

	task automatic directed_points();
		point_t d[$];
		d.push_back('{32'sd0, 32'sd0, 32'sd0});
		d.push_back('{32'sd0, 32'sd0, 32'sh10000});
		d.push_back('{32'sd0, 32'sd0, -32'sh10000});
		d.push_back('{-32'sh10000, 32'sd0, 32'sd0});
		d.push_back('{32'sh10000, 32'sd0, 32'sd0});
		d.push_back('{32'sd0, 32'sh10000, 32'sd0});
		d.push_back('{32'sd0, -32'sh10000, 32'sd0});
		d.push_back('{32'sd1, 32'sd0, 32'sd0});
		d.push_back('{32'sd0, 32'sd0, 32'sd1});
		d.push_back('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
		d.push_back('{32'h80000000, 32'h80000000, 32'h80000000});
		d.push_back('{32'h80000000, 32'h7FFFFFFF, 32'h80000000});
		d.push_back('{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF});
		d.push_back('{-32'sd1, -32'sd1, -32'sd1});
		d.push_back('{32'sh140000, 32'sh50000, -32'sh8000});
		d.push_back('{-32'sh80000, 32'sh30000, 32'sh20000});
		foreach (d[i]) send_point(d[i], 1'b0);
	endtask

	// pixel side: random stalls, one long hold-off on request
	initial begin
		int wait_n;
		pixel.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (stall_long) begin
				pixel.ready <= 1'b0;
				repeat (300) @(posedge clk);
				stall_long = 1'b0;
			end
			wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
			if (wait_n != 0) begin
				pixel.ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			pixel.ready <= 1'b1;
			do @(posedge clk); while (!pixel.valid);
			sb.check_pixel(pixel_t'{pixel.column_index, pixel.row_index,
				pixel.point_invalid});
		end
	end

	// watchdog on accepted items
	always @(posedge clk) begin
		if ((point.valid && point.ready) || (pixel.valid && pixel.ready)
				|| (cfg.valid && cfg.ready) || stim_done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		sb = new();
		idle_cycles = 0;
		stall_long = 1'b0;
		stim_done = 1'b0;
		arst_n = 1'b0;
		point.valid = 1'b0;
		point.point_x = '0;
		point.point_y = '0;
		point.point_z = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_IMAGE_COLUMNS;
		cfg.data = '0;
		m_cols = 13'd2048;
		m_rows = 9'd64;
		m_fov_up = 15'sd300;
		m_fov_down = -15'sd2500;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings
		directed_points();
		random_points(150, 1'b1);
		drain();

		// long output stall while points keep coming
		stall_long = 1'b1;
		random_points(150, 1'b0);
		drain();

		// extremes: largest image, wide field of view
		setup(4096, 256, 9000, -9000);
		directed_points();
		random_points(150, 1'b1);
		drain();

		// out of range sizes, zero field of view
		setup(0, 0, 0, 0);
		random_points(60, 1'b1);
		drain();
		setup(8191, 511, -16384, 16383);
		directed_points();
		random_points(100, 1'b1);
		drain();

		// tiny image, odd field of view, sizes just past the limits
		setup(1, 1, -9000, 9000);
		random_points(60, 1'b1);
		drain();
		setup(1000, 37, 1500, 2200);
		random_points(150, 1'b1);
		drain();
		setup(4097, 257, 2, -1);
		random_points(80, 1'b1);
		drain();

		stim_done = 1'b1;
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/lsp_pkg.sv
sv/lsp_if.sv
sv/lsp_core.sv
sv/lidar_spherical_projection.sv
bench/lidar_spherical_projection_tb.sv
